@@ rtl/svs_pkg.sv @@
// ----------------------------------------------------------------------------
// svs_pkg
// Shared types, codes and helpers for the sparse axis value store.
// ----------------------------------------------------------------------------
package svs_pkg;

    // Field widths of the request and response channels
    localparam int OP_W     = 1;
    localparam int AXIS_W   = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int MASK_W   = 64;
    localparam int SHIFT_W  = 6;

    // Highest axis number held in the presence mask
    localparam logic [AXIS_W-1:0] AXIS_LIMIT = 7'd63;

    // Both signed zero patterns count as zero
    localparam logic [VALUE_W-1:0] ZERO_MASK = 32'h7FFF_FFFF;

    // Operation codes
    localparam logic [OP_W-1:0] OP_GET = 1'b0;
    localparam logic [OP_W-1:0] OP_SET = 1'b1;

    // Response status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } svs_status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_DECIDE,
        ST_READ,
        ST_READ_WAIT,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FINISH
    } svs_state_t;

    // Population count of one byte of the mask
    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

endpackage

@@ rtl/svs_req_if.sv @@
// ----------------------------------------------------------------------------
// svs_req_if
// Request channel: operation, axis number and value word.
// ----------------------------------------------------------------------------
interface svs_req_if
    import svs_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [AXIS_W-1:0]   axis;
    logic [VALUE_W-1:0]  value;

    modport source (output valid, output op, output axis, output value, input ready);
    modport sink   (input valid, input op, input axis, input value, output ready);
endinterface

@@ rtl/svs_rsp_if.sv @@
// ----------------------------------------------------------------------------
// svs_rsp_if
// Response channel: read word, status code and number of held axes.
// ----------------------------------------------------------------------------
interface svs_rsp_if
    import svs_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [VALUE_W-1:0]   read_value;
    logic [STATUS_W-1:0]  status;
    logic [COUNT_W-1:0]   stored_count;

    modport source (output valid, output read_value, output status, output stored_count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input stored_count,
                    output ready);
endinterface

@@ rtl/sparse_axis_value_store_unit.sv @@
// A request is taken only in idle; an in-range axis then has its slot counted and
//   decided on, a get hit reads its word, and an insert moves the words above the
//   slot up one place before writing; an out-of-range axis goes straight to the response.
// One item at a time: the next request is taken only after the response register
//   has loaded the last one.
// Reset: presence mask and count clear at once; entry memory is not cleared.
// ----------------------------------------------------------------------------
// sparse_axis_value_store_unit
// Sparse store of up to MAX_ENTRIES words keyed by axis 0..63, packed in axis
// order behind a 64-bit presence mask and a sequencer over one entry memory.
// ----------------------------------------------------------------------------
module sparse_axis_value_store_unit
    import svs_pkg::*;
#(
    parameter int MAX_ENTRIES = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    svs_req_if.sink    req,
    svs_rsp_if.source  rsp
);

    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_ENTRIES);

    // Control and payload registers
    svs_state_t          state_reg, state_next;
    logic [MASK_W-1:0]   mask_reg,  mask_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  idx_reg,   idx_next;
    logic [OP_W-1:0]     op_reg,    op_next;
    logic [SHIFT_W-1:0]  axis_reg,  axis_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic                present_reg, present_next;
    logic [VALUE_W-1:0]  res_value_reg, res_value_next;
    svs_status_t         res_status_reg, res_status_next;

    // Response register
    logic                rsp_valid_reg, rsp_valid_next;
    logic [VALUE_W-1:0]  rsp_value_reg, rsp_value_next;
    logic [STATUS_W-1:0] rsp_status_reg, rsp_status_next;
    logic [COUNT_W-1:0]  rsp_count_reg, rsp_count_next;

    // Entry memory
    logic [VALUE_W-1:0]  mem [MAX_ENTRIES];
    logic [VALUE_W-1:0]  rd_data_reg;
    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
    logic [VALUE_W-1:0]  mem_wdata;

    // Slot counter
    logic                cnt_start, cnt_done;
    logic [MASK_W-1:0]   cnt_operand;
    logic [COUNT_W-1:0]  slot;

    logic                req_xfer, rsp_free;
    logic [COUNT_W-1:0]  idx_dec;

    assign req_xfer = req.valid && req.ready;
    assign rsp_free = !rsp_valid_reg || rsp.ready;
    assign idx_dec  = idx_reg - COUNT_W'(1);

    assign req.ready = (state_reg == ST_IDLE);

    svs_slot_counter u_slot_counter (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cnt_start),
        .operand (cnt_operand),
        .done    (cnt_done),
        .slot    (slot)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = (req.axis > AXIS_LIMIT) ? ST_FINISH : ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                if (cnt_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (op_reg == OP_GET)
                begin
                    state_next = (present_reg && slot < MAX_COUNT) ? ST_READ : ST_FINISH;
                end
                else if (present_reg || (value_reg & ZERO_MASK) == '0
                         || count_reg >= MAX_COUNT)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_READ:      state_next = ST_READ_WAIT;
            ST_READ_WAIT: state_next = ST_FINISH;
            ST_SHIFT_RD:  state_next = (idx_reg > slot) ? ST_SHIFT_WR : ST_FINISH;
            ST_SHIFT_WR:  state_next = ST_SHIFT_RD;
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        mask_next       = mask_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        axis_next       = axis_reg;
        value_next      = value_reg;
        present_next    = present_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_value_next  = rsp_value_reg;
        rsp_status_next = rsp_status_reg;
        rsp_count_next  = rsp_count_reg;
        cnt_start       = 1'b0;
        cnt_operand     = mask_reg & ((MASK_W'(1) << req.axis[SHIFT_W-1:0]) - MASK_W'(1));
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = idx_reg[ADDR_W-1:0];
        mem_raddr       = slot[ADDR_W-1:0];
        mem_wdata       = value_reg;
        case (state_reg)
            ST_IDLE:
            begin
                // Capture the request and start the slot count
                if (req_xfer)
                begin
                    op_next         = req.op;
                    axis_next       = req.axis[SHIFT_W-1:0];
                    value_next      = req.value;
                    present_next    = mask_reg[req.axis[SHIFT_W-1:0]];
                    res_value_next  = '0;
                    res_status_next = (req.axis > AXIS_LIMIT) ? STATUS_RANGE : STATUS_OK;
                    cnt_start       = (req.axis <= AXIS_LIMIT);
                end
            end
            ST_DECIDE:
            begin
                if (op_reg == OP_SET)
                begin
                    if (present_reg)
                    begin
                        // Overwrite in place, zero included
                        mem_we    = (slot < MAX_COUNT);
                        mem_waddr = slot[ADDR_W-1:0];
                    end
                    else if ((value_reg & ZERO_MASK) != '0)
                    begin
                        if (count_reg >= MAX_COUNT)
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            // Mark the axis and open a slot from the top down
                            mask_next  = mask_reg | (MASK_W'(1) << axis_reg);
                            count_next = count_reg + COUNT_W'(1);
                            idx_next   = count_reg;
                        end
                    end
                end
            end
            ST_READ:
            begin
                mem_re = 1'b1;
            end
            ST_READ_WAIT:
            begin
                res_value_next = rd_data_reg;
            end
            ST_SHIFT_RD:
            begin
                if (idx_reg > slot)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_dec[ADDR_W-1:0];
                end
                else
                begin
                    // Slot is open: drop the new word in
                    mem_we = 1'b1;
                end
            end
            ST_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg;
                idx_next  = idx_dec;
            end
            ST_FINISH:
            begin
                // Hold until the response register is free
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_value_next  = res_value_reg;
                    rsp_status_next = res_status_reg;
                    rsp_count_next  = count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mask_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mask_reg      <= mask_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        op_reg         <= op_next;
        axis_reg       <= axis_next;
        value_reg      <= value_next;
        present_reg    <= present_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        rsp_value_reg  <= rsp_value_next;
        rsp_status_reg <= rsp_status_next;
        rsp_count_reg  <= rsp_count_next;
    end

    // Entry memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.read_value   = rsp_value_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.stored_count = rsp_count_reg;

`ifndef SYNTHESIS
    // Count tracks the mask
    a_count_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == COUNT_W'($countones(mask_reg)))
        else $error("stored count differs from presence mask population");

    // Never hold more than the store size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT)
        else $error("stored count above store size");

    // Full is reported only when the store is full
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_status_reg == STATUS_FULL |-> rsp_count_reg == MAX_COUNT)
        else $error("full status with free slots");

    // An insert sweep stays inside the memory
    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SHIFT_WR |-> idx_reg < MAX_COUNT && idx_reg > slot)
        else $error("shift index outside occupied range");
`endif

endmodule

@@ rtl/svs_slot_counter.sv @@
// ----------------------------------------------------------------------------
// svs_slot_counter
// Counts the set bits of a 64-bit operand one byte per cycle, eight bytes in
// turn, using a single byte-wide population count unit.
// ----------------------------------------------------------------------------
module svs_slot_counter
    import svs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MASK_W-1:0]  operand,
    output logic               done,
    output logic [COUNT_W-1:0] slot
);

    logic [MASK_W-1:0]  scan_reg,  scan_next;
    logic [2:0]         chunk_reg, chunk_next;
    logic [COUNT_W-1:0] acc_reg,   acc_next;
    logic               run_reg,   run_next;

    // Load on start, then fold in one byte per cycle
    always_comb
    begin
        scan_next  = scan_reg;
        chunk_next = chunk_reg;
        acc_next   = acc_reg;
        run_next   = run_reg;
        if (start)
        begin
            scan_next  = operand;
            chunk_next = 3'd0;
            acc_next   = '0;
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            acc_next   = acc_reg + {3'd0, popcount8(scan_reg[7:0])};
            scan_next  = {8'd0, scan_reg[MASK_W-1:8]};
            chunk_next = chunk_reg + 3'd1;
            if (chunk_reg == 3'd7)
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            chunk_reg <= 3'd0;
            acc_reg   <= '0;
        end
        else
        begin
            run_reg   <= run_next;
            chunk_reg <= chunk_next;
            acc_reg   <= acc_next;
        end
    end

    // Operand shift line carries payload only
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
    end

    // Last byte folds in at this edge
    assign done = run_reg && (chunk_reg == 3'd7);
    assign slot = acc_reg;

endmodule

@@ bench/sparse_axis_value_store_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_axis_value_store_unit_test
// Drives get and set requests into the sparse axis value store and checks
// every response against a cycle-free model of the presence mask and the
// packed word store. Covers empty, partly filled and full stores, signed zero
// words, out-of-range axes, random handshake gaps and long response stalls.
// ----------------------------------------------------------------------------
module sparse_axis_value_store_unit_test;
    import svs_pkg::*;

    localparam int STORE_DEPTH   = 32;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        svs_status_t        status;
        logic [COUNT_W-1:0] stored_count;
    } axis_reply_t;

    logic clk = 1'b0;
    logic rst_n;

    svs_req_if req_ch ();
    svs_rsp_if rsp_ch ();

    sparse_axis_value_store_unit #(
        .MAX_ENTRIES (STORE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Model state: presence mask and packed words
    logic [MASK_W-1:0]  held_mask;
    logic [VALUE_W-1:0] held_words [0:STORE_DEPTH-1];

    axis_reply_t pending_replies [$];
    int          error_count;
    int          send_idle_pct;
    int          rsp_idle_pct;
    int          quiet_cycles;
    logic        hold_toggle;
    logic        hold_seen;
    int          hold_left;

    // Clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned ones_in(input logic [MASK_W-1:0] v);
        int unsigned n;
        n = 0;
        for (int i = 0; i < MASK_W; i++)
        begin
            if (v[i])
                n++;
        end
        return n;
    endfunction

    // Apply one request to the model and return the response it causes
    function automatic axis_reply_t predict_reply(input logic [OP_W-1:0] op,
                                                  input logic [AXIS_W-1:0] axis,
                                                  input logic [VALUE_W-1:0] value);
        axis_reply_t r;
        int unsigned slot;
        int unsigned count;
        logic        present;
        r.read_value = '0;
        r.status     = STATUS_OK;
        if (axis > AXIS_LIMIT)
        begin
            r.status = STATUS_RANGE;
        end
        else
        begin
            present = held_mask[axis[SHIFT_W-1:0]];
            slot    = ones_in(held_mask & ((64'd1 << axis[SHIFT_W-1:0]) - 64'd1));
            if (op == OP_GET)
            begin
                if (present && slot < STORE_DEPTH)
                    r.read_value = held_words[slot];
            end
            else if (present)
            begin
                if (slot < STORE_DEPTH)
                    held_words[slot] = value;
            end
            else if ((value & ZERO_MASK) != '0)
            begin
                count = ones_in(held_mask);
                if (count >= STORE_DEPTH)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    held_mask[axis[SHIFT_W-1:0]] = 1'b1;
                    for (int unsigned i = count; i > slot; i--)
                        held_words[i] = held_words[i-1];
                    held_words[slot] = value;
                end
            end
        end
        r.stored_count = COUNT_W'(ones_in(held_mask));
        return r;
    endfunction

    // Offer one request, wait for its transfer, then record the expected reply
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [AXIS_W-1:0] axis,
                                input logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.axis  <= axis;
        req_ch.value <= value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_replies = {pending_replies, predict_reply(op, axis, value)};
    endtask

    task automatic park_request();
        req_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        park_request();
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [AXIS_W-1:0] pick_axis(input logic want_present);
        logic [AXIS_W-1:0] a;
        int unsigned       held;
        held = ones_in(held_mask);
        a = AXIS_W'($urandom_range(63));
        if (want_present && held != 0)
        begin
            while (!held_mask[a[SHIFT_W-1:0]])
                a = AXIS_W'($urandom_range(63));
        end
        else if (!want_present && held != MASK_W)
        begin
            while (held_mask[a[SHIFT_W-1:0]])
                a = AXIS_W'($urandom_range(63));
        end
        return a;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return 32'h0000_0000;
        if (r < 10)
            return 32'h8000_0000;
        return $urandom;
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        return $urandom_range(1) ? OP_SET : OP_GET;
    endfunction

    // Empty store, range rejects, zero words, inserts and overwrites
    task automatic test_directed();
        send_request(OP_GET, 7'd0,   32'h0000_0000);
        send_request(OP_GET, 7'd127, 32'hFFFF_FFFF);
        send_request(OP_SET, 7'd64,  32'hFFFF_FFFF);
        send_request(OP_GET, 7'd64,  32'h0000_0000);
        send_request(OP_SET, 7'd5,   32'h0000_0000);
        send_request(OP_SET, 7'd5,   32'h8000_0000);
        send_request(OP_GET, 7'd5,   32'h0000_0000);
        send_request(OP_SET, 7'd63,  32'hFFFF_FFFF);
        send_request(OP_SET, 7'd0,   32'h0000_0001);
        send_request(OP_SET, 7'd31,  32'h7FFF_FFFF);
        send_request(OP_GET, 7'd63,  32'h0000_0000);
        send_request(OP_GET, 7'd0,   32'h0000_0000);
        send_request(OP_GET, 7'd31,  32'h0000_0000);
        send_request(OP_SET, 7'd31,  32'h8000_0000);
        send_request(OP_GET, 7'd31,  32'h0000_0000);
        send_request(OP_SET, 7'd31,  32'h0000_0000);
        send_request(OP_GET, 7'd31,  32'h0000_0000);
        send_request(OP_GET, 7'd32,  32'h0000_0000);
        send_request(OP_SET, 7'd127, 32'h0000_0000);
        send_request(OP_SET, 7'd1,   32'h8000_0001);
        send_request(OP_GET, 7'd1,   32'h0000_0000);
        send_request(OP_GET, 7'd100, 32'h5555_AAAA);
    endtask

    // Hold the response side for a long stretch while requests keep coming
    task automatic test_backpressure();
        int saved_pct;
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        hold_toggle   = ~hold_toggle;
        for (int i = 0; i < 8; i++)
            send_request(i[0] ? OP_SET : OP_GET, pick_axis(i[1]), pick_value());
        send_idle_pct = saved_pct;
        wait_drained();
    endtask

    // Mostly gets and overwrites; inserts are spread thin so the fill spans phases
    task automatic test_random_mix(input int count);
        int unsigned r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 8)
                send_request(OP_SET, pick_axis(1'b0), pick_value());
            else if (r < 14)
                send_request(pick_op(), AXIS_W'($urandom_range(127, 64)), $urandom);
            else if (r < 34)
                send_request(OP_GET, pick_axis(1'b1), $urandom);
            else if (r < 52)
                send_request(OP_GET, pick_axis(1'b0), $urandom);
            else
                send_request(OP_SET, pick_axis(1'b1), pick_value());
        end
    endtask

    // Fill the store, then hit it with inserts, zero sets, overwrites and reads
    task automatic test_full_store();
        while (ones_in(held_mask) < STORE_DEPTH)
            send_request(OP_SET, pick_axis(1'b0), $urandom | 32'h0000_0001);
        send_request(OP_SET, pick_axis(1'b0), 32'hFFFF_FFFF);
        send_request(OP_SET, pick_axis(1'b0), 32'h8000_0000);
        send_request(OP_SET, pick_axis(1'b0), 32'h0000_0000);
        send_request(OP_SET, pick_axis(1'b1), 32'h0000_0000);
        send_request(OP_SET, pick_axis(1'b1), $urandom);
        send_request(OP_SET, 7'd64, $urandom);
        for (int a = 0; a < MASK_W; a++)
            send_request(OP_GET, AXIS_W'(a), $urandom);
    endtask

    // Response side: stall, long hold-off, and compare each transfer
    always @(posedge clk)
    begin
        axis_reply_t want;
        if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        rsp_ch.ready <= (hold_left == 0) && (hold_toggle == hold_seen)
                        && ($urandom_range(99) >= rsp_idle_pct);
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected reply value=%h status=%0d count=%0d", $time,
                         rsp_ch.read_value, rsp_ch.status, rsp_ch.stored_count);
                error_count = error_count + 1;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (rsp_ch.read_value !== want.read_value)
                begin
                    $display("%0t: read_value expected %h actual %h", $time,
                             want.read_value, rsp_ch.read_value);
                    error_count = error_count + 1;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, rsp_ch.status);
                    error_count = error_count + 1;
                end
                if (rsp_ch.stored_count !== want.stored_count)
                begin
                    $display("%0t: stored_count expected %0d actual %0d", $time,
                             want.stored_count, rsp_ch.stored_count);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("sparse_axis_value_store_unit_test: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.op     = OP_GET;
        req_ch.axis   = '0;
        req_ch.value  = '0;
        rsp_ch.ready  = 1'b0;
        held_mask     = '0;
        error_count   = 0;
        quiet_cycles  = 0;
        hold_toggle   = 1'b0;
        hold_seen     = 1'b0;
        hold_left     = 0;
        send_idle_pct = 18;
        rsp_idle_pct  = 57;
        for (int i = 0; i < STORE_DEPTH; i++)
            held_words[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random_mix(220);

        send_idle_pct = 57;
        rsp_idle_pct  = 18;
        test_random_mix(220);

        send_idle_pct = 0;
        rsp_idle_pct  = 0;
        test_random_mix(220);
        test_full_store();

        // Drain and let any stray reply show up
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("sparse_axis_value_store_unit_test: clean");
        else
            $display("sparse_axis_value_store_unit_test: errors");
        $finish;
    end

endmodule

@@ sparse_axis_value_store_unit.f @@
rtl/svs_pkg.sv
rtl/svs_req_if.sv
rtl/svs_rsp_if.sv
rtl/svs_slot_counter.sv
rtl/sparse_axis_value_store_unit.sv
bench/sparse_axis_value_store_unit_test.sv
